>>> hw/rtl/pia_pkg.sv
package pia_pkg;

    // Field widths of the request and result items.
    localparam int CMD_W   = 3;
    localparam int POS_W   = 7;
    localparam int VALUE_W = 32;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 7;

    // Stream word widths, padded to whole bytes.
    localparam int IN_FIELDS_W  = CMD_W + POS_W + VALUE_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = VALUE_W + STAT_W + COUNT_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    // Command codes carried in a request.
    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_BACK  = 3'd0,
        CMD_PUSH_FRONT = 3'd1,
        CMD_INSERT     = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_POP_FRONT  = 3'd4,
        CMD_READ       = 3'd5
    } cmd_t;

    // Status codes returned with every result.
    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_BAD_INDEX = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    // Operations the cell chain performs.
    typedef enum logic [1:0] {
        OP_NONE       = 2'd0,
        OP_INSERT     = 2'd1,
        OP_SHIFT_LEFT = 2'd2
    } dp_op_t;

endpackage

>>> hw/rtl/pia_cell_chain.sv
module pia_cell_chain #(
    parameter int CAPACITY      = 64,
    parameter int ELEMENT_WIDTH = 32,
    parameter int AW            = $clog2(CAPACITY)
) (
    input  logic                     clk,
    input  pia_pkg::dp_op_t          op,
    input  logic [AW-1:0]            slot,
    input  logic [ELEMENT_WIDTH-1:0] word,
    input  logic [AW-1:0]            rd_idx,
    output logic [ELEMENT_WIDTH-1:0] rd_data
);

    logic [ELEMENT_WIDTH-1:0] cell_reg [CAPACITY];
    logic [ELEMENT_WIDTH-1:0] sel_data [CAPACITY];

    // Each cell loads the new word, takes its left or right neighbor, or holds.
    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
        if (gi == 0) begin : g_first
            always_ff @(posedge clk)
            begin
                if (op == pia_pkg::OP_INSERT && slot == AW'(gi)) begin
                    cell_reg[gi] <= word;
                end else if (op == pia_pkg::OP_SHIFT_LEFT) begin
                    cell_reg[gi] <= cell_reg[gi+1];
                end
            end
        end else if (gi == CAPACITY - 1) begin : g_last
            always_ff @(posedge clk)
            begin
                if (op == pia_pkg::OP_INSERT) begin
                    if (slot == AW'(gi)) begin
                        cell_reg[gi] <= word;
                    end else if (AW'(gi) > slot) begin
                        cell_reg[gi] <= cell_reg[gi-1];
                    end
                end
            end
        end else begin : g_mid
            always_ff @(posedge clk)
            begin
                if (op == pia_pkg::OP_INSERT) begin
                    if (slot == AW'(gi)) begin
                        cell_reg[gi] <= word;
                    end else if (AW'(gi) > slot) begin
                        cell_reg[gi] <= cell_reg[gi-1];
                    end
                end else if (op == pia_pkg::OP_SHIFT_LEFT) begin
                    cell_reg[gi] <= cell_reg[gi+1];
                end
            end
        end

        // Each cell drives its word onto the read bus when its index is selected.
        assign sel_data[gi] = (rd_idx == AW'(gi)) ? cell_reg[gi] : '0;
    end

    // Combine the one-hot selected words.
    always_comb
    begin
        rd_data = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            rd_data = rd_data | sel_data[i];
        end
    end

endmodule

>>> hw/rtl/pia_ctrl.sv
module pia_ctrl #(
    parameter int CAPACITY      = 64,
    parameter int ELEMENT_WIDTH = 32,
    parameter int AW            = $clog2(CAPACITY)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // Request side
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [pia_pkg::CMD_W-1:0]     in_cmd,
    input  logic [pia_pkg::POS_W-1:0]     in_pos,
    input  logic [pia_pkg::VALUE_W-1:0]   in_value,
    // Result side
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [pia_pkg::VALUE_W-1:0]   out_value,
    output logic [pia_pkg::STAT_W-1:0]    out_status,
    output logic [pia_pkg::COUNT_W-1:0]   out_count,
    // Cell chain commands
    output pia_pkg::dp_op_t               dp_op,
    output logic [AW-1:0]                 dp_slot,
    output logic [ELEMENT_WIDTH-1:0]      dp_word,
    output logic [AW-1:0]                 dp_rd_idx,
    input  logic [ELEMENT_WIDTH-1:0]      dp_rd_data
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > pia_pkg::POS_W) ? CW : pia_pkg::POS_W;
    localparam int OW = (PW > pia_pkg::COUNT_W) ? PW : pia_pkg::COUNT_W;
    localparam int RW = (ELEMENT_WIDTH > pia_pkg::VALUE_W) ? ELEMENT_WIDTH
                                                           : pia_pkg::VALUE_W;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t                          state_reg, state_next;
    logic                            in_ready_reg, in_ready_next;
    logic [pia_pkg::CMD_W-1:0]       cmd_reg, cmd_next;
    logic [pia_pkg::POS_W-1:0]       pos_reg, pos_next;
    logic [ELEMENT_WIDTH-1:0]        word_reg, word_next;
    logic [CW-1:0]                   count_reg, count_next;
    logic                            out_valid_reg, out_valid_next;
    logic [pia_pkg::VALUE_W-1:0]     out_value_reg, out_value_next;
    logic [pia_pkg::STAT_W-1:0]      out_status_reg, out_status_next;
    logic [pia_pkg::COUNT_W-1:0]     out_count_reg, out_count_next;

    logic                            go;
    logic                            pos_ok;
    logic                            full;
    logic                            empty;
    logic [PW-1:0]                   pos_ext;
    logic [PW-1:0]                   cnt_ext;
    logic [pia_pkg::POS_W-1:0]       pos_m1;
    logic [RW-1:0]                   in_value_ext;
    logic [RW-1:0]                   rd_data_ext;
    logic [OW-1:0]                   count_ext;
    pia_pkg::dp_op_t                 op;
    pia_pkg::status_t                st;
    logic                            take;

    // Width adaptation between the port fields and the element width.
    assign in_value_ext = RW'(in_value);
    assign rd_data_ext  = RW'(dp_rd_data);

    // Index checks on the held request.
    assign pos_ext = PW'(pos_reg);
    assign cnt_ext = PW'(count_reg);
    assign pos_m1  = pos_reg - 1'b1;
    assign pos_ok  = (pos_reg != '0) && (pos_ext <= cnt_ext);
    assign full    = (count_reg == CW'(CAPACITY));
    assign empty   = (count_reg == '0);

    // The held request executes once the result register can take its result.
    assign go = (state_reg == S_EXEC) && (!out_valid_reg || out_ready);

    // Decode the held request into a chain operation, a status and a new count.
    always_comb
    begin
        op         = pia_pkg::OP_NONE;
        st         = pia_pkg::ST_OK;
        take       = 1'b0;
        dp_slot    = '0;
        dp_rd_idx  = '0;
        count_next = count_reg;
        case (pia_pkg::cmd_t'(cmd_reg))
            pia_pkg::CMD_PUSH_BACK:
            begin
                if (full) begin
                    st = pia_pkg::ST_FULL;
                end else begin
                    op         = pia_pkg::OP_INSERT;
                    dp_slot    = AW'(count_reg);
                    count_next = count_reg + 1'b1;
                end
            end
            pia_pkg::CMD_PUSH_FRONT:
            begin
                if (full) begin
                    st = pia_pkg::ST_FULL;
                end else begin
                    op         = pia_pkg::OP_INSERT;
                    count_next = count_reg + 1'b1;
                end
            end
            pia_pkg::CMD_INSERT:
            begin
                if (!pos_ok) begin
                    st = pia_pkg::ST_BAD_INDEX;
                end else if (full) begin
                    st = pia_pkg::ST_FULL;
                end else begin
                    op         = pia_pkg::OP_INSERT;
                    dp_slot    = AW'(pos_m1);
                    count_next = count_reg + 1'b1;
                end
            end
            pia_pkg::CMD_POP_BACK:
            begin
                if (empty) begin
                    st = pia_pkg::ST_EMPTY;
                end else begin
                    take       = 1'b1;
                    dp_rd_idx  = AW'(count_reg - 1'b1);
                    count_next = count_reg - 1'b1;
                end
            end
            pia_pkg::CMD_POP_FRONT:
            begin
                if (empty) begin
                    st = pia_pkg::ST_EMPTY;
                end else begin
                    op         = pia_pkg::OP_SHIFT_LEFT;
                    take       = 1'b1;
                    count_next = count_reg - 1'b1;
                end
            end
            pia_pkg::CMD_READ:
            begin
                if (!pos_ok) begin
                    st = pia_pkg::ST_BAD_INDEX;
                end else begin
                    take      = 1'b1;
                    dp_rd_idx = AW'(pos_m1);
                end
            end
            default:
            begin
                st = pia_pkg::ST_BAD_INDEX;
            end
        endcase
    end

    assign dp_op     = go ? op : pia_pkg::OP_NONE;
    assign dp_word   = word_reg;
    assign count_ext = OW'(count_next);

    // Next-state logic for the sequencer and the result register.
    always_comb
    begin
        state_next      = state_reg;
        in_ready_next   = in_ready_reg;
        cmd_next        = cmd_reg;
        pos_next        = pos_reg;
        word_next       = word_reg;
        out_valid_next  = out_valid_reg;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        out_count_next  = out_count_reg;

        if (out_valid_reg && out_ready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready_reg) begin
                    cmd_next      = in_cmd;
                    pos_next      = in_pos;
                    word_next     = in_value_ext[ELEMENT_WIDTH-1:0];
                    in_ready_next = 1'b0;
                    state_next    = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (go) begin
                    out_valid_next  = 1'b1;
                    out_value_next  = take ? rd_data_ext[pia_pkg::VALUE_W-1:0] : '0;
                    out_status_next = st;
                    out_count_next  = count_ext[pia_pkg::COUNT_W-1:0];
                    in_ready_next   = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next    = S_IDLE;
                in_ready_next = 1'b1;
            end
        endcase
    end

    // State, count and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg      <= S_IDLE;
            in_ready_reg   <= 1'b1;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
            out_value_reg  <= '0;
            out_status_reg <= '0;
            out_count_reg  <= '0;
        end else begin
            state_reg      <= state_next;
            in_ready_reg   <= in_ready_next;
            out_valid_reg  <= out_valid_next;
            out_value_reg  <= out_value_next;
            out_status_reg <= out_status_next;
            out_count_reg  <= out_count_next;
            if (go) begin
                count_reg <= count_next;
            end
        end
    end

    // Held request fields.
    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        pos_reg  <= pos_next;
        word_reg <= word_next;
    end

    assign in_ready   = in_ready_reg;
    assign out_valid  = out_valid_reg;
    assign out_value  = out_value_reg;
    assign out_status = out_status_reg;
    assign out_count  = out_count_reg;

endmodule

>>> hw/rtl/positional_insert_array_unit.sv
// Channel   | Direction | Handshake                      | Payload
// ----------+-----------+--------------------------------+-------------------------------------
// Request   | in        | s_tvalid / s_tready            | s_tdata: cmd, position, item_value
// Result    | out       | m_tvalid / m_tready            | m_tdata: read_value, status, count
//
// Each request is first captured, then run through the cell chain in the execute state,
// where the affected cells all shift to their neighbors together.
// The result register frees the request side while a result waits to be taken.
// A stalled result holds the request in its execute state until m_tready.
// Reset clears the element count; cell contents are undefined until written.
module positional_insert_array_unit #(
    parameter int CAPACITY      = 64,
    parameter int ELEMENT_WIDTH = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Request stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // s_tdata, low to high: cmd[2:0], position[9:3], item_value[41:10], zero pad
    input  logic [pia_pkg::IN_TDATA_W-1:0]      s_tdata,
    // Result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // m_tdata, low to high: read_value[31:0], status[33:32], element_count[40:34], zero pad
    output logic [pia_pkg::OUT_TDATA_W-1:0]     m_tdata
);

    localparam int AW = $clog2(CAPACITY);

    logic [pia_pkg::CMD_W-1:0]     cmd;
    logic [pia_pkg::POS_W-1:0]     position;
    logic [pia_pkg::VALUE_W-1:0]   item_value;
    logic [pia_pkg::VALUE_W-1:0]   read_value;
    logic [pia_pkg::STAT_W-1:0]    status;
    logic [pia_pkg::COUNT_W-1:0]   element_count;

    pia_pkg::dp_op_t               dp_op;
    logic [AW-1:0]                 dp_slot;
    logic [AW-1:0]                 dp_rd_idx;
    logic [ELEMENT_WIDTH-1:0]      dp_word;
    logic [ELEMENT_WIDTH-1:0]      dp_rd_data;

    // Unpack the request word.
    assign cmd        = s_tdata[pia_pkg::CMD_W-1:0];
    assign position   = s_tdata[pia_pkg::CMD_W +: pia_pkg::POS_W];
    assign item_value = s_tdata[pia_pkg::CMD_W + pia_pkg::POS_W +: pia_pkg::VALUE_W];

    // Pack the result word.
    assign m_tdata = {{(pia_pkg::OUT_TDATA_W - pia_pkg::OUT_FIELDS_W){1'b0}},
                      element_count, status, read_value};

    // Command sequencer with the count and result register.
    pia_ctrl #(
        .CAPACITY      (CAPACITY),
        .ELEMENT_WIDTH (ELEMENT_WIDTH),
        .AW            (AW)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_cmd     (cmd),
        .in_pos     (position),
        .in_value   (item_value),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_value  (read_value),
        .out_status (status),
        .out_count  (element_count),
        .dp_op      (dp_op),
        .dp_slot    (dp_slot),
        .dp_word    (dp_word),
        .dp_rd_idx  (dp_rd_idx),
        .dp_rd_data (dp_rd_data)
    );

    // Register chain holding the elements.
    pia_cell_chain #(
        .CAPACITY      (CAPACITY),
        .ELEMENT_WIDTH (ELEMENT_WIDTH),
        .AW            (AW)
    ) u_chain (
        .clk     (clk),
        .op      (dp_op),
        .slot    (dp_slot),
        .word    (dp_word),
        .rd_idx  (dp_rd_idx),
        .rd_data (dp_rd_data)
    );

endmodule

>>> tb/tb.sv
module tb;

    localparam int CAPACITY    = 64;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DIR_N       = 23;
    localparam int RAND_N      = 550;
    localparam int DRAIN_WAIT  = 20;

    // Field and stream widths taken from the package.
    localparam int CMD_W       = pia_pkg::CMD_W;
    localparam int POS_W       = pia_pkg::POS_W;
    localparam int VALUE_W     = pia_pkg::VALUE_W;
    localparam int STAT_W      = pia_pkg::STAT_W;
    localparam int COUNT_W     = pia_pkg::COUNT_W;
    localparam int IN_TDATA_W  = pia_pkg::IN_TDATA_W;
    localparam int OUT_TDATA_W = pia_pkg::OUT_TDATA_W;

    typedef pia_pkg::status_t status_t;
    typedef pia_pkg::cmd_t    cmd_t;

    // Command codes outside the defined set.
    localparam logic [CMD_W-1:0] CMD_UNUSED_6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_UNUSED_7 = 3'd7;

    // Biases of the random request mix.
    localparam int MODE_MIX    = 0;
    localparam int MODE_GROW   = 1;
    localparam int MODE_SHRINK = 2;

    // Result field offsets in m_tdata.
    localparam int STAT_LSB  = VALUE_W;
    localparam int COUNT_LSB = VALUE_W + STAT_W;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        status_t            status;
        logic [COUNT_W-1:0] count;
    } array_result_t;

    typedef struct {
        logic [CMD_W-1:0]   op;
        logic [POS_W-1:0]   pos;
        logic [VALUE_W-1:0] val;
        bit                 typed;
        array_result_t      res;
    } dir_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    // Shadow copy of the array contents and fill level.
    logic [VALUE_W-1:0]     shadow_cells [CAPACITY];
    int                     shadow_fill;

    array_result_t          pending_results [$];
    dir_row_t               dir_tbl [DIR_N];

    int                     mismatch_cnt = 0;
    int                     results_taken = 0;
    int                     status_hits [4] = '{0, 0, 0, 0};
    int                     peak_count = 0;
    int                     cycle_cnt = 0;
    int                     hold_left = 0;
    bit                     hold_done = 1'b0;

    positional_insert_array_unit #(
        .CAPACITY      (CAPACITY),
        .ELEMENT_WIDTH (VALUE_W)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Clock generation.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Run the shadow array through one request and return the result it yields.
    // A refused request leaves the shadow state untouched.
    function automatic array_result_t apply_array_cmd(logic [CMD_W-1:0] op,
                                                      logic [POS_W-1:0] pos,
                                                      logic [VALUE_W-1:0] val);
        array_result_t r;
        bit            pos_ok;
        int            k;
        r.value  = '0;
        r.status = pia_pkg::ST_OK;
        pos_ok   = (pos >= 1) && (int'(pos) <= shadow_fill);
        case (op)
            pia_pkg::CMD_PUSH_BACK:
            begin
                if (shadow_fill >= CAPACITY)
                    r.status = pia_pkg::ST_FULL;
                else
                begin
                    shadow_cells[shadow_fill] = val;
                    shadow_fill++;
                end
            end
            pia_pkg::CMD_PUSH_FRONT:
            begin
                if (shadow_fill >= CAPACITY)
                    r.status = pia_pkg::ST_FULL;
                else
                begin
                    for (k = shadow_fill; k > 0; k--)
                        shadow_cells[k] = shadow_cells[k-1];
                    shadow_cells[0] = val;
                    shadow_fill++;
                end
            end
            pia_pkg::CMD_INSERT:
            begin
                // The index check takes priority over the full check.
                if (!pos_ok)
                    r.status = pia_pkg::ST_BAD_INDEX;
                else if (shadow_fill >= CAPACITY)
                    r.status = pia_pkg::ST_FULL;
                else
                begin
                    for (k = shadow_fill; k > int'(pos) - 1; k--)
                        shadow_cells[k] = shadow_cells[k-1];
                    shadow_cells[pos-1] = val;
                    shadow_fill++;
                end
            end
            pia_pkg::CMD_POP_BACK:
            begin
                if (shadow_fill == 0)
                    r.status = pia_pkg::ST_EMPTY;
                else
                begin
                    shadow_fill--;
                    r.value = shadow_cells[shadow_fill];
                end
            end
            pia_pkg::CMD_POP_FRONT:
            begin
                if (shadow_fill == 0)
                    r.status = pia_pkg::ST_EMPTY;
                else
                begin
                    r.value = shadow_cells[0];
                    for (k = 0; k + 1 < shadow_fill; k++)
                        shadow_cells[k] = shadow_cells[k+1];
                    shadow_fill--;
                end
            end
            pia_pkg::CMD_READ:
            begin
                if (!pos_ok)
                    r.status = pia_pkg::ST_BAD_INDEX;
                else
                    r.value = shadow_cells[pos-1];
            end
            default:
                r.status = pia_pkg::ST_BAD_INDEX;
        endcase
        r.count = COUNT_W'(shadow_fill);
        return r;
    endfunction

    function automatic dir_row_t typed_row(logic [CMD_W-1:0] op, logic [POS_W-1:0] pos,
                                           logic [VALUE_W-1:0] val, logic [VALUE_W-1:0] rv,
                                           status_t st, logic [COUNT_W-1:0] cnt);
        dir_row_t row;
        row.op           = op;
        row.pos          = pos;
        row.val          = val;
        row.typed        = 1'b1;
        row.res.value    = rv;
        row.res.status   = st;
        row.res.count    = cnt;
        return row;
    endfunction

    function automatic dir_row_t pred_row(logic [CMD_W-1:0] op, logic [POS_W-1:0] pos,
                                          logic [VALUE_W-1:0] val);
        dir_row_t row;
        row       = typed_row(op, pos, val, '0, pia_pkg::ST_OK, '0);
        row.typed = 1'b0;
        return row;
    endfunction

    // Offer one request, wait for it to be taken, then record its expected result.
    task automatic send_request(input logic [CMD_W-1:0] op, input logic [POS_W-1:0] pos,
                                input logic [VALUE_W-1:0] val, input bit quiet,
                                input bit typed, input array_result_t typed_res);
        array_result_t predicted;
        if (!quiet && $urandom_range(0, 99) < 27)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_TDATA_W'({val, pos, op});
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predicted = apply_array_cmd(op, pos, val);
        pending_results.insert(pending_results.size(), typed ? typed_res : predicted);
    endtask

    // Pick a random request. Most are well formed with positions inside the array,
    // the rest is noise over the whole field range.
    task automatic pick_request(input int mode, output logic [CMD_W-1:0] op,
                                output logic [POS_W-1:0] pos, output logic [VALUE_W-1:0] val);
        int    weights [6];
        cmd_t  op_order [6];
        int    r;
        int    hi;
        int    sel;
        int    i;
        op_order = '{pia_pkg::CMD_PUSH_BACK, pia_pkg::CMD_PUSH_FRONT, pia_pkg::CMD_INSERT,
                     pia_pkg::CMD_READ, pia_pkg::CMD_POP_BACK, pia_pkg::CMD_POP_FRONT};
        case (mode)
            MODE_GROW:   weights = '{30, 20, 20, 15, 8, 7};
            MODE_SHRINK: weights = '{10, 5, 5, 15, 35, 30};
            default:     weights = '{15, 10, 12, 25, 19, 19};
        endcase
        sel = $urandom_range(0, 15);
        val = (sel == 0) ? '0 : (sel == 1) ? '1 : VALUE_W'($urandom);
        r   = $urandom_range(0, 99);
        if (r < ((mode == MODE_MIX) ? 10 : 4))
        begin
            op  = CMD_W'($urandom_range(0, 7));
            pos = POS_W'($urandom_range(0, 127));
        end
        else
        begin
            r  = $urandom_range(0, 99);
            op = op_order[5];
            for (i = 0; i < 6; i++)
            begin
                if (r < weights[i])
                begin
                    op = op_order[i];
                    break;
                end
                r -= weights[i];
            end
            hi  = (shadow_fill == 0) ? 1 : shadow_fill;
            sel = $urandom_range(0, 9);
            pos = POS_W'((sel == 0) ? 1 : (sel == 1) ? hi : $urandom_range(1, hi));
        end
    endtask

    // Result receiver readiness: random stalls, a quiet stretch, and one long hold-off.
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end
        else if (!hold_done && results_taken >= 330)
        begin
            hold_left = 250;
            hold_done = 1'b1;
            m_tready <= 1'b0;
        end
        else if (results_taken >= 150 && results_taken < 260)
            m_tready <= 1'b1;
        else
            m_tready <= ($urandom_range(0, 99) >= 27);
    end

    // Compare every result taken against the oldest expectation.
    always @(posedge clk)
    begin : result_check
        array_result_t got;
        array_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.value     = m_tdata[VALUE_W-1:0];
            got.status    = status_t'(m_tdata[STAT_LSB +: STAT_W]);
            got.count     = m_tdata[COUNT_LSB +: COUNT_W];
            results_taken <= results_taken + 1;
            if (pending_results.size() == 0)
            begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("Unexpected result: value %h status %0d count %0d",
                             got.value, got.status, got.count);
            end
            else
            begin
                want = pending_results[0];
                pending_results.delete(0);
                if (got.value !== want.value || got.status !== want.status ||
                    got.count !== want.count)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("Result mismatch: expected value %h status %0d count %0d,",
                                 want.value, want.status, want.count,
                                 " got value %h status %0d count %0d",
                                 got.value, got.status, got.count);
                end
                status_hits[want.status]++;
                if (int'(want.count) > peak_count)
                    peak_count = int'(want.count);
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("tb failed");
            $finish;
        end
    end

    // Stimulus: directed table first, then phases of biased random requests.
    initial
    begin : stimulus
        logic [CMD_W-1:0]   op;
        logic [POS_W-1:0]   pos;
        logic [VALUE_W-1:0] val;
        int                 req_idx;
        int                 mode;
        int                 n;
        shadow_fill = 0;
        foreach (shadow_cells[k])
            shadow_cells[k] = '0;
        dir_tbl = '{
            // Every way of failing on an empty array, and the unused codes.
            typed_row(pia_pkg::CMD_POP_BACK, 7'd0, 32'h0, 32'h0, pia_pkg::ST_EMPTY, 7'd0),
            typed_row(pia_pkg::CMD_POP_FRONT, 7'd0, 32'h0, 32'h0, pia_pkg::ST_EMPTY, 7'd0),
            typed_row(pia_pkg::CMD_READ, 7'd1, 32'h0, 32'h0, pia_pkg::ST_BAD_INDEX, 7'd0),
            typed_row(pia_pkg::CMD_INSERT, 7'd1, 32'hDEADBEEF, 32'h0,
                      pia_pkg::ST_BAD_INDEX, 7'd0),
            typed_row(CMD_UNUSED_6, 7'd0, 32'h0, 32'h0, pia_pkg::ST_BAD_INDEX, 7'd0),
            typed_row(CMD_UNUSED_7, 7'd127, 32'hFFFFFFFF, 32'h0, pia_pkg::ST_BAD_INDEX, 7'd0),
            // Value extremes at both ends, then reads around the valid range.
            typed_row(pia_pkg::CMD_PUSH_BACK, 7'd0, 32'hFFFFFFFF, 32'h0, pia_pkg::ST_OK, 7'd1),
            typed_row(pia_pkg::CMD_PUSH_FRONT, 7'd0, 32'h0, 32'h0, pia_pkg::ST_OK, 7'd2),
            typed_row(pia_pkg::CMD_READ, 7'd2, 32'h0, 32'hFFFFFFFF, pia_pkg::ST_OK, 7'd2),
            typed_row(pia_pkg::CMD_READ, 7'd3, 32'h0, 32'h0, pia_pkg::ST_BAD_INDEX, 7'd2),
            typed_row(pia_pkg::CMD_READ, 7'd0, 32'h0, 32'h0, pia_pkg::ST_BAD_INDEX, 7'd2),
            // Insertion just past the last element is refused.
            typed_row(pia_pkg::CMD_INSERT, 7'd3, 32'h11111111, 32'h0,
                      pia_pkg::ST_BAD_INDEX, 7'd2),
            typed_row(pia_pkg::CMD_INSERT, 7'd0, 32'h22222222, 32'h0,
                      pia_pkg::ST_BAD_INDEX, 7'd2),
            pred_row(pia_pkg::CMD_INSERT,    7'd2,  32'h12345678),
            pred_row(pia_pkg::CMD_INSERT,    7'd1,  32'hA5A5A5A5),
            pred_row(pia_pkg::CMD_PUSH_BACK, 7'd0,  32'h80000001),
            pred_row(pia_pkg::CMD_READ,      7'd3,  32'h0),
            pred_row(pia_pkg::CMD_READ,      7'd5,  32'h0),
            pred_row(pia_pkg::CMD_READ,      7'd64, 32'h0),
            pred_row(pia_pkg::CMD_POP_FRONT, 7'd0,  32'h0),
            pred_row(pia_pkg::CMD_POP_BACK,  7'd0,  32'h0),
            pred_row(pia_pkg::CMD_INSERT,    7'd64, 32'h5A5A5A5A),
            pred_row(CMD_UNUSED_6,           7'd2,  32'h0)
        };

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        req_idx = 0;
        foreach (dir_tbl[i])
        begin
            send_request(dir_tbl[i].op, dir_tbl[i].pos, dir_tbl[i].val, 1'b0,
                         dir_tbl[i].typed, dir_tbl[i].res);
            req_idx++;
        end

        // Grow phase biases requests toward filling the array; shrink phase toward draining it.
        for (n = 0; n < RAND_N; n++)
        begin
            if (n < 90)
                mode = MODE_MIX;
            else if (n < 240)
                mode = MODE_GROW;
            else if (n < 360)
                mode = MODE_MIX;
            else if (n < 480)
                mode = MODE_SHRINK;
            else
                mode = MODE_MIX;

            // Hold back new requests until every result is back.
            if (n == 480)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
                while (pending_results.size() != 0)
                    @(posedge clk);
            end

            pick_request(mode, op, pos, val);
            send_request(op, pos, val, (req_idx >= 175 && req_idx < 285), 1'b0, '0);
            req_idx++;
        end
        s_tvalid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("Sent %0d requests; results ok %0d, bad index %0d, empty %0d, full %0d.",
                 req_idx, status_hits[pia_pkg::ST_OK], status_hits[pia_pkg::ST_BAD_INDEX],
                 status_hits[pia_pkg::ST_EMPTY], status_hits[pia_pkg::ST_FULL]);
        $display("Peak element count %0d of %0d; %0d mismatches.",
                 peak_count, CAPACITY, mismatch_cnt);
        if (mismatch_cnt == 0 && pending_results.size() == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
